[rtl/point_in_polygon_test_defines.svh]
// Assertion macros for the point-in-polygon test block.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Checked on every clock edge outside reset
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included
`define PIP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pip_pkg.sv]
// Shared constants and types for the point-in-polygon test block.
// No dependencies; used by every module under rtl.
package pip_pkg;

  // Store and coordinate sizing
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // Differences need one bit more than a coordinate, products twice that
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Request modes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEST   = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // Sequencer to crossing unit
  typedef struct packed {
    logic load;     // take edge and test point, form operands
    logic mul_lhs;  // multiply (tx - xi) by |dy|
    logic mul_rhs;  // multiply (xj - xi) by sign-corrected offset
  } cu_ctrl_t;

  // Crossing unit to sequencer
  typedef struct packed {
    logic straddle; // edge spans the test y
    logic less;     // crossing lies strictly right of the test x
  } cu_stat_t;

endpackage

[rtl/point_in_polygon_test.sv]
// Point-in-polygon test: sequencer, vertex count and result registers.
// Depends on pip_pkg, pip_vertex_store, pip_cross_unit and the assertion macros.
//
// A request is taken when start is high and busy is low. Clear and append
// requests finish in the accepting cycle and their result strobes on done
// in the next cycle. A test request keeps busy high while it walks the
// stored vertices: the store gives one vertex a cycle while no spanning
// edge holds the walk, and an edge that spans the test y goes through the
// single 33 x 33 multiplier once for each side of the crossing compare,
// then through the compare itself. The result is on inside_res and status
// for the one cycle that done is high and must be taken then; it cannot be
// held off.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test import pip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  coord_t     x_coord,
  input  coord_t     y_coord,
  output logic       busy,
  output logic       done,
  output logic       inside_res,
  output logic       status
);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_CMP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] idx;
  logic              parity;
  coord_t            tx, ty, prev_x, prev_y;

  logic              wr_en, rd_en, last;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  count_m1;
  coord_t            rd_x, rd_y;
  cu_ctrl_t          cu_ctrl;
  cu_stat_t          cu_stat;

  assign busy     = state != S_IDLE;
  assign count_m1 = count - CNT_W'(1);
  assign last     = CNT_W'(idx) == count_m1;

  // Store write on an append request with room left
  assign wr_en = (state == S_IDLE) && start && (mode == MODE_APPEND) && (count != MAX_COUNT);

  // Store read: last vertex first, then vertices in order
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx + ADDR_W'(1);
    case (state)
      S_IDLE: begin
        rd_en   = start && (mode == MODE_TEST) && (count != '0);
        rd_addr = count_m1[ADDR_W-1:0];
      end
      S_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_DIFF:  rd_en = !cu_stat.straddle && !last;
      S_CMP:   rd_en = !last;
      default: rd_en = 1'b0;
    endcase
  end

  assign cu_ctrl.load    = state == S_DIFF;
  assign cu_ctrl.mul_lhs = state == S_MUL1;
  assign cu_ctrl.mul_rhs = state == S_MUL2;

  pip_vertex_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_x    (x_coord),
    .wr_y    (y_coord),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pip_cross_unit u_cross (
    .clk  (clk),
    .ctrl (cu_ctrl),
    .tx   (tx),
    .ty   (ty),
    .xi   (rd_x),
    .yi   (rd_y),
    .xj   (prev_x),
    .yj   (prev_y),
    .stat (cu_stat)
  );

  // Sequencer, vertex count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      parity     <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      status     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tx         <= x_coord;
            ty         <= y_coord;
            idx        <= '0;
            parity     <= 1'b0;
            inside_res <= 1'b0;
            status     <= 1'b0;
            case (mode)
              MODE_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              MODE_APPEND: begin
                if (count == MAX_COUNT) begin
                  status <= 1'b1;
                end else begin
                  count <= count + CNT_W'(1);
                end
                done <= 1'b1;
              end
              MODE_TEST: begin
                // empty polygon answers outside at once
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_PRIME;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_PRIME: begin
          // closing edge starts at the last vertex
          prev_x <= rd_x;
          prev_y <= rd_y;
          state  <= S_DIFF;
        end
        S_DIFF: begin
          if (cu_stat.straddle) begin
            state <= S_MUL1;
          end else begin
            prev_x <= rd_x;
            prev_y <= rd_y;
            if (last) begin
              inside_res <= parity;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_CMP;
        S_CMP: begin
          prev_x <= rd_x;
          prev_y <= rd_y;
          if (last) begin
            inside_res <= parity ^ cu_stat.less;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            parity <= parity ^ cu_stat.less;
            idx    <= idx + ADDR_W'(1);
            state  <= S_DIFF;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `PIP_ASSERT(a_done_when_idle, done |-> !busy, "result strobe while still busy")
  `PIP_ASSERT(a_count_bound, count <= MAX_COUNT, "vertex count beyond store depth")
  `PIP_ASSERT(a_full_flag, done && status |-> count == MAX_COUNT, "drop flagged on non-full store")
  `PIP_ASSERT(a_walk_bound, busy && state != S_PRIME |-> CNT_W'(idx) < count, "edge index past count")
  `PIP_ASSERT_RST(a_reset_quiet, rst |=> !busy && !done, "activity straight after reset")

endmodule

[rtl/pip_vertex_store.sv]
// Vertex memory: one write port, one read port with registered data.
// Depends on pip_pkg for sizing and the coordinate type.
module pip_vertex_store import pip_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  coord_t            wr_x,
  input  coord_t            wr_y,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output coord_t            rd_x,
  output coord_t            rd_y
);

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_x, rd_y} <= mem[rd_addr];
    end
  end

endmodule

[rtl/pip_cross_unit.sv]
// Edge crossing datapath: operand forming, one shared signed multiplier, compare.
// Depends on pip_pkg for widths and the control and status structs.
module pip_cross_unit import pip_pkg::*; (
  input  logic     clk,
  input  cu_ctrl_t ctrl,
  input  coord_t   tx,
  input  coord_t   ty,
  input  coord_t   xi,
  input  coord_t   yi,
  input  coord_t   xj,
  input  coord_t   yj,
  output cu_stat_t stat
);

  diff_t dy, off, dy_abs, off_adj;
  diff_t op_a1, op_b1, op_a2, op_b2;
  diff_t mul_a, mul_b;
  prod_t prod, lhs, rhs;

  // Edge differences, sign corrected so the scale factor is positive
  always_comb begin
    dy      = diff_t'(yj) - diff_t'(yi);
    off     = diff_t'(ty) - diff_t'(yi);
    dy_abs  = dy[DIFF_W-1] ? -dy : dy;
    off_adj = dy[DIFF_W-1] ? -off : off;
  end

  assign stat.straddle = (yi > ty) != (yj > ty);

  // Operand registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_a1 <= diff_t'(tx) - diff_t'(xi);
      op_b1 <= dy_abs;
      op_a2 <= diff_t'(xj) - diff_t'(xi);
      op_b2 <= off_adj;
    end
  end

  // Shared multiplier, one product per cycle
  always_comb begin
    mul_a = ctrl.mul_rhs ? op_a2 : op_a1;
    mul_b = ctrl.mul_rhs ? op_b2 : op_b1;
    prod  = prod_t'(mul_a) * prod_t'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_lhs) begin
      lhs <= prod;
    end
    if (ctrl.mul_rhs) begin
      rhs <= prod;
    end
  end

  assign stat.less = lhs < rhs;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for point_in_polygon_test: its own crossing-parity
// model predicts every result. Depends on pip_pkg and the point_in_polygon_test RTL.
`timescale 1ns / 100ps

module tb_top import pip_pkg::*; ();

  // How the coordinates of one polygon and its test points are drawn
  typedef enum int {
    STYLE_GRID,
    STYLE_WIDE,
    STYLE_EXTREME,
    STYLE_FINE
  } coord_style_t;

  typedef struct {
    mode_t  mode;
    coord_t x;
    coord_t y;
  } request_t;

  typedef struct {
    logic in_poly;
    logic status;
  } verdict_t;

  typedef logic signed [127:0] wide_t;

  localparam int     UNIT      = 1048576;  // 1.0 in Q11.20
  localparam int     HALF_UNIT = 524288;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam int     N_REQUESTS = 450;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic [1:0] mode = MODE_CLEAR;
  coord_t x_coord = '0;
  coord_t y_coord = '0;
  logic   busy;
  logic   done;
  logic   inside_res;
  logic   status;

  point_in_polygon_test i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .busy       (busy),
    .done       (done),
    .inside_res (inside_res),
    .status     (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the polygon store
  coord_t      poly_x [MAX_VERTICES];
  coord_t      poly_y [MAX_VERTICES];
  int unsigned poly_len = 0;

  request_t pending_q [$];
  verdict_t verdict_q [$];
  int       fail_count = 0;

  // Stimulus bookkeeping
  int  n_queued = 0;
  int  gen_len = 0;
  bit  burst = 1'b0;

  // Odd-even crossing count over all edges, closing edge first; the crossing
  // compare is scaled by |dy| so it stays exact
  function automatic logic crossing_parity(coord_t tx, coord_t ty);
    logic        parity;
    int unsigned i;
    int unsigned j;
    wide_t       dy;
    wide_t       off;
    wide_t       lhs;
    wide_t       rhs;
    parity = 1'b0;
    if (poly_len == 0) return 1'b0;
    j = poly_len - 1;
    for (i = 0; i < poly_len; i++) begin
      if ((poly_y[i] > ty) != (poly_y[j] > ty)) begin
        dy  = wide_t'(poly_y[j]) - wide_t'(poly_y[i]);
        off = wide_t'(ty) - wide_t'(poly_y[i]);
        if (dy < 0) begin
          dy  = -dy;
          off = -off;
        end
        lhs = (wide_t'(tx) - wide_t'(poly_x[i])) * dy;
        rhs = (wide_t'(poly_x[j]) - wide_t'(poly_x[i])) * off;
        if (lhs < rhs) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  // Applies one accepted request to the shadow store, returns its result
  function automatic verdict_t apply_request(request_t r);
    verdict_t v;
    v.in_poly = 1'b0;
    v.status = 1'b0;
    case (r.mode)
      MODE_CLEAR: poly_len = 0;
      MODE_APPEND: begin
        if (poly_len >= MAX_VERTICES) begin
          v.status = 1'b1;
        end else begin
          poly_x[poly_len] = r.x;
          poly_y[poly_len] = r.y;
          poly_len++;
        end
      end
      MODE_TEST: v.in_poly = crossing_parity(r.x, r.y);
      default: ;
    endcase
    return v;
  endfunction

  function automatic coord_t pick_coord(coord_style_t style);
    int     step;
    coord_t c;
    case (style)
      STYLE_GRID: begin
        step = int'($urandom_range(0, 16)) - 8;
        c = coord_t'(step * UNIT);
      end
      STYLE_WIDE: c = coord_t'($urandom);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: c = COORD_MIN;
          1: c = COORD_MAX;
          2: c = '0;
          3: c = '1;
          default: c = coord_t'($urandom);
        endcase
      end
      default: c = coord_t'(int'($urandom_range(0, 4 * UNIT - 1)) - 2 * UNIT);
    endcase
    return c;
  endfunction

  // Grid polygons half of the time: ties and horizontal edges come often
  function automatic coord_style_t pick_style();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return STYLE_GRID;
    if (roll < 7) return STYLE_WIDE;
    if (roll < 8) return STYLE_EXTREME;
    return STYLE_FINE;
  endfunction

  task automatic push_request(mode_t m, coord_t x, coord_t y);
    request_t r;
    r.mode = m;
    r.x = x;
    r.y = y;
    pending_q.push_back(r);
    if (m != MODE_SPARE) n_queued++;
    if (m == MODE_CLEAR) gen_len = 0;
    else if (m == MODE_APPEND && gen_len < MAX_VERTICES) gen_len++;
  endtask

  // Test point near the polygon, half a step off the grid now and then
  task automatic push_test(coord_style_t style);
    coord_t tx;
    coord_t ty;
    tx = pick_coord(style);
    ty = pick_coord(style);
    if (style == STYLE_GRID && $urandom_range(0, 1)) tx = tx + HALF_UNIT;
    if (style == STYLE_GRID && $urandom_range(0, 2) == 0) ty = ty + HALF_UNIT;
    push_request(MODE_TEST, tx, ty);
  endtask

  // Stray request of any mode, anywhere in a sequence
  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0)
      push_request(mode_t'($urandom_range(0, 3)), coord_t'($urandom), coord_t'($urandom));
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : int'($urandom_range(0, 16));
  endfunction

  // Driver: presents queued requests, predicting each one as it is taken
  request_t cur_req;
  int       hold_cycles = 0;
  logic     launch;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_cycles = draw_gap();
    end else begin
      launch = 1'b0;
      if (start && !busy) begin
        verdict_q.push_back(apply_request(cur_req));
        hold_cycles = draw_gap();
        if (hold_cycles == 0 && pending_q.size() != 0) launch = 1'b1;
        else start <= 1'b0;
      end else if (!start) begin
        if (hold_cycles > 0) hold_cycles--;
        if (hold_cycles == 0 && pending_q.size() != 0) launch = 1'b1;
      end
      if (launch) begin
        cur_req = pending_q.pop_front();
        start   <= 1'b1;
        mode    <= cur_req.mode;
        x_coord <= cur_req.x;
        y_coord <= cur_req.y;
      end
    end
  end

  // Monitor: every strobed result against the oldest prediction
  verdict_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, inside_res %0b status %0b", $time,
                 inside_res, status);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (inside_res !== want.in_poly) begin
          $display("%0t: inside_res expected %0b actual %0b", $time, want.in_poly,
                   inside_res);
          fail_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, status);
          fail_count++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    coord_style_t style;
    int           n_verts;
    int           n_tests;
    int           k;
    bit           filled;
    filled = 1'b0;

    // Directed: empty store, spare mode, degenerate polygons, extremes
    push_request(MODE_TEST, '0, '0);
    push_request(MODE_TEST, COORD_MIN, COORD_MAX);
    push_request(MODE_SPARE, '1, '1);
    push_request(MODE_CLEAR, COORD_MAX, COORD_MIN);
    push_request(MODE_APPEND, '0, '0);
    push_request(MODE_TEST, coord_t'(-UNIT), '0);
    push_request(MODE_APPEND, coord_t'(4 * UNIT), '0);
    push_request(MODE_TEST, coord_t'(UNIT), '0);
    push_request(MODE_CLEAR, '0, '0);
    push_request(MODE_APPEND, '0, '0);
    push_request(MODE_APPEND, coord_t'(8 * UNIT), '0);
    push_request(MODE_APPEND, '0, coord_t'(8 * UNIT));
    push_request(MODE_TEST, coord_t'(UNIT), coord_t'(UNIT));
    push_request(MODE_TEST, coord_t'(6 * UNIT), coord_t'(6 * UNIT));
    push_request(MODE_TEST, coord_t'(-UNIT), coord_t'(UNIT));
    push_request(MODE_TEST, coord_t'(UNIT), '0);
    push_request(MODE_CLEAR, '0, '0);
    push_request(MODE_APPEND, COORD_MIN, COORD_MIN);
    push_request(MODE_APPEND, COORD_MAX, COORD_MIN);
    push_request(MODE_APPEND, '0, COORD_MAX);
    push_request(MODE_TEST, '0, '0);
    push_request(MODE_TEST, COORD_MAX, COORD_MAX);
    push_request(MODE_TEST, COORD_MIN, '0);
    push_request(MODE_SPARE, COORD_MIN, COORD_MAX);
    push_request(MODE_TEST, '0, '0);

    // Random: mostly clear / append / several tests, with stray requests
    while (n_queued < N_REQUESTS) begin
      style = pick_style();
      if (!filled && n_queued > 150) begin
        // One full store, overfilled so the last appends are dropped
        push_request(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom));
        for (k = 0; k < MAX_VERTICES + 2; k++)
          push_request(MODE_APPEND, pick_coord(style), pick_coord(style));
        for (k = 0; k < 6; k++) push_test(style);
        filled = 1'b1;
      end else begin
        n_verts = ($urandom_range(0, 7) == 0) ? int'($urandom_range(12, 30))
                                              : int'($urandom_range(0, 10));
        if ($urandom_range(0, 9) != 0 || gen_len + n_verts > 40)
          push_request(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom));
        for (k = 0; k < n_verts; k++) begin
          push_request(MODE_APPEND, pick_coord(style), pick_coord(style));
          maybe_noise();
        end
        n_tests = $urandom_range(1, 8);
        for (k = 0; k < n_tests; k++) begin
          push_test(style);
          maybe_noise();
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pending_q.size() != 0 || start);
    do @(negedge clk); while (verdict_q.size() != 0);
    repeat (20) @(negedge clk);

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("PASS point_in_polygon_test");
    end else begin
      $display("FAIL point_in_polygon_test");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAIL point_in_polygon_test");
    $finish;
  end

endmodule
